// File: rtl/i2p_pkg.sv
// Shared types, codes and helper functions for the infix-to-postfix converter.
package i2p_pkg;

  // Input item: one ASCII byte of the infix expression
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_byte;
  } in_item_t;

  // Result item: one postfix byte or the terminator
  typedef struct packed {
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expression_end;
    logic [1:0] error_code;
  } out_item_t;

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5,
    OP_LBRK = 3'd6
  } op_code_t;

  // Item classes produced by the front end
  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_OPERAND,
    KIND_OPER,
    KIND_OPEN,
    KIND_CLOSE
  } kind_t;

  // Classified item carried through the queue
  typedef struct packed {
    kind_t      kind;
    op_code_t   code;
    logic [7:0] symbol;
    logic       fin;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_CLOSE,
    ST_FLUSH,
    ST_TERM
  } state_t;

  // Error flag bits
  localparam int ERR_OVERFLOW_BIT = 0;
  localparam int ERR_UNMATCHED_BIT = 1;

  // ASCII bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  // Map a stack code back to its character
  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] ch;
    case (code)
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_STAR;
      OP_DIV:  ch = CH_SLASH;
      OP_LPAR: ch = CH_LPAR;
      OP_LBRK: ch = CH_LBRK;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Operator precedence; openers rank lowest
  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/i2p_front.sv
// Front end: accepts input bytes and classifies them into commands.
module i2p_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  i2p_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               enq,
  output i2p_pkg::cmd_t      enq_cmd
);

  // Take an item whenever the queue has room
  assign in_ready = !q_full;
  assign enq      = in_valid && !q_full;

  // Classify the byte
  always_comb begin
    enq_cmd.symbol = in_item.symbol;
    enq_cmd.fin    = in_item.final_byte;
    enq_cmd.code   = i2p_pkg::OP_NONE;
    enq_cmd.kind   = i2p_pkg::KIND_OPERAND;
    case (in_item.symbol)
      i2p_pkg::CH_SPACE, i2p_pkg::CH_NUL: begin
        enq_cmd.kind = i2p_pkg::KIND_SKIP;
      end
      i2p_pkg::CH_PLUS: begin
        enq_cmd.kind = i2p_pkg::KIND_OPER;
        enq_cmd.code = i2p_pkg::OP_ADD;
      end
      i2p_pkg::CH_MINUS: begin
        enq_cmd.kind = i2p_pkg::KIND_OPER;
        enq_cmd.code = i2p_pkg::OP_SUB;
      end
      i2p_pkg::CH_STAR: begin
        enq_cmd.kind = i2p_pkg::KIND_OPER;
        enq_cmd.code = i2p_pkg::OP_MUL;
      end
      i2p_pkg::CH_SLASH: begin
        enq_cmd.kind = i2p_pkg::KIND_OPER;
        enq_cmd.code = i2p_pkg::OP_DIV;
      end
      i2p_pkg::CH_LPAR: begin
        enq_cmd.kind = i2p_pkg::KIND_OPEN;
        enq_cmd.code = i2p_pkg::OP_LPAR;
      end
      i2p_pkg::CH_LBRK: begin
        enq_cmd.kind = i2p_pkg::KIND_OPEN;
        enq_cmd.code = i2p_pkg::OP_LBRK;
      end
      i2p_pkg::CH_RPAR, i2p_pkg::CH_RBRK: begin
        enq_cmd.kind = i2p_pkg::KIND_CLOSE;
      end
      default: begin
        enq_cmd.kind = i2p_pkg::KIND_OPERAND;
      end
    endcase
  end

endmodule

// File: rtl/i2p_queue.sv
// Two-entry command queue between the front end and the back end.
module i2p_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           enq,
  input  i2p_pkg::cmd_t  enq_cmd,
  output logic           full,
  output logic           q_valid,
  output i2p_pkg::cmd_t  q_cmd,
  input  logic           deq
);

  i2p_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ enq;
    rd_ptr_nxt = rd_ptr_r ^ deq;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (enq) begin
      entry_r[wr_ptr_r] <= enq_cmd;
    end
  end

endmodule

// File: rtl/i2p_back.sv
// Back end: operator stack, pop sequencer and output register.
module i2p_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  i2p_pkg::cmd_t      q_cmd,
  output logic               deq,
  output logic               out_valid,
  input  logic               out_ready,
  output i2p_pkg::out_item_t out_item
);

  localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  i2p_pkg::op_code_t  stack_mem [STACK_DEPTH];
  i2p_pkg::op_code_t  top_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         err_r, err_nxt;
  i2p_pkg::state_t    state_r, state_nxt;
  i2p_pkg::cmd_t      cmd_r;
  logic               held_v_r, held_v_nxt;
  logic [7:0]         held_sym_r;
  logic               out_valid_r, out_valid_nxt;
  i2p_pkg::out_item_t out_item_r;

  logic               out_free;
  logic               stk_empty;
  logic               stk_full;
  logic               top_open;
  logic               loop_more;
  logic               step_ok;

  logic               emit;
  i2p_pkg::out_item_t emit_item;
  logic               push_req;
  i2p_pkg::op_code_t  push_code;
  logic               pop;
  logic               hold_load;
  logic               hold_drop;
  logic               cmd_load;
  logic               err_unmatched;
  logic               err_clear;

  logic               push_en;
  logic [PW-1:0]      rd_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign stk_empty = (cnt_r == '0);
  assign stk_full  = (cnt_r == CW'(STACK_DEPTH));
  assign top_open  = (top_r == i2p_pkg::OP_LPAR) || (top_r == i2p_pkg::OP_LBRK);
  assign step_ok   = !held_v_r || out_free;

  // Decide whether the current pop loop continues
  always_comb begin
    case (state_r)
      i2p_pkg::ST_OPER:
        loop_more = !stk_empty &&
                    (i2p_pkg::code_prec(cmd_r.code) <= i2p_pkg::code_prec(top_r));
      i2p_pkg::ST_CLOSE: loop_more = !stk_empty && !top_open;
      i2p_pkg::ST_FLUSH: loop_more = !stk_empty;
      default:           loop_more = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2p_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            i2p_pkg::KIND_OPERAND: begin
              if (out_free) begin
                state_nxt = q_cmd.fin ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
              end
            end
            i2p_pkg::KIND_OPER:  state_nxt = i2p_pkg::ST_OPER;
            i2p_pkg::KIND_CLOSE: state_nxt = i2p_pkg::ST_CLOSE;
            default: state_nxt = q_cmd.fin ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
          endcase
        end
      end
      i2p_pkg::ST_OPER, i2p_pkg::ST_CLOSE: begin
        if (step_ok && !loop_more) begin
          state_nxt = cmd_r.fin ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
        end
      end
      i2p_pkg::ST_FLUSH: begin
        if (step_ok && !loop_more) begin
          state_nxt = i2p_pkg::ST_TERM;
        end
      end
      i2p_pkg::ST_TERM: begin
        if (out_free) begin
          state_nxt = i2p_pkg::ST_IDLE;
        end
      end
      default: state_nxt = i2p_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    deq           = 1'b0;
    emit          = 1'b0;
    emit_item     = '0;
    push_req      = 1'b0;
    push_code     = cmd_r.code;
    pop           = 1'b0;
    hold_load     = 1'b0;
    hold_drop     = 1'b0;
    cmd_load      = 1'b0;
    err_unmatched = 1'b0;
    err_clear     = 1'b0;
    case (state_r)
      i2p_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            i2p_pkg::KIND_OPERAND: begin
              if (out_free) begin
                deq                  = 1'b1;
                emit                 = 1'b1;
                emit_item.out_symbol = q_cmd.symbol;
                emit_item.run_last   = !q_cmd.fin;
              end
            end
            i2p_pkg::KIND_OPEN: begin
              deq       = 1'b1;
              push_req  = 1'b1;
              push_code = q_cmd.code;
            end
            i2p_pkg::KIND_OPER, i2p_pkg::KIND_CLOSE: begin
              deq      = 1'b1;
              cmd_load = 1'b1;
            end
            default: begin
              deq = 1'b1;
            end
          endcase
        end
      end
      i2p_pkg::ST_OPER, i2p_pkg::ST_CLOSE, i2p_pkg::ST_FLUSH: begin
        if (step_ok) begin
          // Release the byte popped on the previous step, now that its successor is known
          emit                 = held_v_r;
          emit_item.out_symbol = held_sym_r;
          emit_item.run_last   = !loop_more && !cmd_r.fin &&
                                 (state_r != i2p_pkg::ST_FLUSH);
          hold_load            = loop_more;
          hold_drop            = !loop_more;
          pop                  = loop_more;
          if (!loop_more) begin
            if (state_r == i2p_pkg::ST_OPER) begin
              push_req = 1'b1;
            end else if (state_r == i2p_pkg::ST_CLOSE) begin
              // Discard the matching opener, or flag a closer without one
              pop           = !stk_empty;
              err_unmatched = stk_empty;
            end
          end
        end
      end
      i2p_pkg::ST_TERM: begin
        if (out_free) begin
          emit                     = 1'b1;
          emit_item.out_symbol     = i2p_pkg::CH_NUL;
          emit_item.run_last       = 1'b1;
          emit_item.expression_end = 1'b1;
          emit_item.error_code     = err_r;
          err_clear                = 1'b1;
        end
      end
      default: begin
        deq = 1'b0;
      end
    endcase
  end

  // Stack pointer, flags and held byte
  assign push_en = push_req && !stk_full;
  assign rd_idx  = PW'(cnt_r - CW'(2));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    err_nxt = err_r;
    if (err_clear) begin
      err_nxt = 2'b00;
    end else begin
      if (push_req && stk_full) begin
        err_nxt[i2p_pkg::ERR_OVERFLOW_BIT] = 1'b1;
      end
      if (err_unmatched) begin
        err_nxt[i2p_pkg::ERR_UNMATCHED_BIT] = 1'b1;
      end
    end
    held_v_nxt = held_v_r;
    if (hold_load) begin
      held_v_nxt = 1'b1;
    end else if (hold_drop) begin
      held_v_nxt = 1'b0;
    end
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2p_pkg::ST_IDLE;
      cnt_r       <= '0;
      err_r       <= 2'b00;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_r <= q_cmd;
    end
    if (hold_load) begin
      held_sym_r <= i2p_pkg::code_char(top_r);
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  // Stack memory; top of stack kept in a register, refilled on pop
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[cnt_r[PW-1:0]] <= push_code;
      top_r                    <= push_code;
    end else if (pop && (cnt_r >= CW'(2))) begin
      top_r <= stack_mem[rd_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: front end, queue and back end.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid/in_ready   | in_item  (symbol, final_byte)
//  out_    | output    | out_valid/out_ready | out_item (out_symbol, run_last,
//          |           |                     |   expression_end, error_code)
//
// The back end takes an operand, space or opener straight from the queue, and runs
// a pop loop for an operator or closer; a final byte flushes the remaining stack
// entries and sends the terminator. The stack has one read and one write port, so
// pops proceed at one per cycle while the output is not stalled.
// The front end takes an item whenever the two-entry queue has room.
// Reset (rst_n low, synchronous) empties the queue, the stack and the flags.
// A stalled output holds its item; the sequencer waits to emit while the output is full.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2p_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output i2p_pkg::out_item_t out_item
);

  logic          q_full;
  logic          enq;
  i2p_pkg::cmd_t enq_cmd;
  logic          q_valid;
  i2p_pkg::cmd_t q_cmd;
  logic          deq;

  // Classify incoming bytes
  i2p_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .enq      (enq),
    .enq_cmd  (enq_cmd)
  );

  // Decouple front and back
  i2p_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .full    (q_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .deq     (deq)
  );

  // Run the stack and produce results
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .deq       (deq),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: rtl/i2p_checker.sv
// Port-level checks on the converter's result channel, bound to the top level.
module i2p_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input i2p_pkg::out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Terminator closes the run of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.expression_end |-> out_item.run_last)
    else $error("terminator without run_last");

  // Terminator carries a zero byte, every other result a nonzero one
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.expression_end == (out_item.out_symbol == 8'h00)))
    else $error("terminator byte mismatch");

  // Errors are reported on the terminator only
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.error_code != 2'b00) |-> out_item.expression_end)
    else $error("error code outside terminator");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: sim/testbench.sv
// Testbench for the infix-to-postfix converter: directed table, random expressions, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'(1 << i2p_pkg::ERR_UNMATCHED_BIT);
  localparam i2p_pkg::out_item_t NO_RES = '0;
  localparam logic [7:0] OPER_CH [4] = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS,
                                         i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH};

  // One stimulus row; known marks a row whose single result is typed in
  typedef struct packed {
    logic [7:0]         sym;
    logic               fin;
    logic               known;
    i2p_pkg::out_item_t res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  i2p_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  i2p_pkg::out_item_t out_item;

  // Operator stack mirror and expected postfix stream
  i2p_pkg::op_code_t  opstk [DEPTH];
  int                 stk_cnt = 0;
  logic [1:0]         err_flags = 2'b00;
  i2p_pkg::out_item_t step_res [$];
  i2p_pkg::out_item_t postfix_q [$];
  stim_row_t          stim_q [$];
  stim_row_t          cur_row = '0;
  int                 fail_cnt = 0;

  // Directed part: extremes, every operator, skips, closers, flushes
  stim_row_t directed_tbl [0:25] = '{
    '{"a",               1'b0, 1'b1, '{"a", 1'b1, 1'b0, ERR_OK}},
    '{i2p_pkg::CH_SPACE, 1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_NUL,   1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_LPAR,  1'b0, 1'b0, NO_RES},
    '{"b",               1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_PLUS,  1'b0, 1'b0, NO_RES},
    '{"c",               1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_STAR,  1'b0, 1'b0, NO_RES},
    '{8'hFF,             1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{"d",               1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{"e",               1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_RPAR,  1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_LBRK,  1'b0, 1'b0, NO_RES},
    '{"f",               1'b0, 1'b0, NO_RES},
    '{i2p_pkg::CH_RBRK,  1'b0, 1'b0, NO_RES},
    // opener still stacked at the end is flushed like an operator
    '{i2p_pkg::CH_LPAR,  1'b1, 1'b0, NO_RES},
    // closer on an empty stack, then terminator only
    '{i2p_pkg::CH_RPAR,  1'b1, 1'b1, '{i2p_pkg::CH_NUL, 1'b1, 1'b1, ERR_UNMATCHED}},
    '{i2p_pkg::CH_SPACE, 1'b1, 1'b1, '{i2p_pkg::CH_NUL, 1'b1, 1'b1, ERR_OK}},
    '{i2p_pkg::CH_NUL,   1'b1, 1'b1, '{i2p_pkg::CH_NUL, 1'b1, 1'b1, ERR_OK}},
    '{8'hFF,             1'b1, 1'b0, NO_RES},
    '{"g",               1'b0, 1'b1, '{"g", 1'b1, 1'b0, ERR_OK}},
    '{i2p_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    // closer with operators but no opener below them
    '{i2p_pkg::CH_RBRK,  1'b0, 1'b0, NO_RES},
    '{"h",               1'b1, 1'b0, NO_RES}
  };

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Count a failure, report the first few
  task automatic note_failure(input string msg);
    if (fail_cnt < 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    fail_cnt++;
  endtask

  function automatic int rank_of(input i2p_pkg::op_code_t c);
    case (c)
      i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 1;
      i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2;
      default:                          return 0;
    endcase
  endfunction

  task automatic add_result(input logic [7:0] sym, input logic term, input logic [1:0] err);
    i2p_pkg::out_item_t r;
    r.out_symbol = sym;
    r.run_last = 1'b0;
    r.expression_end = term;
    r.error_code = err;
    step_res.push_back(r);
  endtask

  // Pop the top entry and emit its character
  task automatic pop_to_result();
    logic [7:0] ch;
    stk_cnt--;
    case (opstk[stk_cnt])
      i2p_pkg::OP_ADD:  ch = i2p_pkg::CH_PLUS;
      i2p_pkg::OP_SUB:  ch = i2p_pkg::CH_MINUS;
      i2p_pkg::OP_MUL:  ch = i2p_pkg::CH_STAR;
      i2p_pkg::OP_DIV:  ch = i2p_pkg::CH_SLASH;
      i2p_pkg::OP_LPAR: ch = i2p_pkg::CH_LPAR;
      i2p_pkg::OP_LBRK: ch = i2p_pkg::CH_LBRK;
      default:          ch = i2p_pkg::CH_NUL;
    endcase
    add_result(ch, 1'b0, ERR_OK);
  endtask

  // Push, or drop and flag overflow on a full stack
  task automatic push_code(input i2p_pkg::op_code_t c);
    if (stk_cnt >= DEPTH) begin
      err_flags[i2p_pkg::ERR_OVERFLOW_BIT] = 1'b1;
    end else begin
      opstk[stk_cnt] = c;
      stk_cnt++;
    end
  endtask

  // Work out the postfix results one input byte causes
  task automatic shunt_symbol(input logic [7:0] sym, input logic fin);
    i2p_pkg::op_code_t  code;
    i2p_pkg::out_item_t tail;
    step_res.delete();
    case (sym)
      i2p_pkg::CH_PLUS:  code = i2p_pkg::OP_ADD;
      i2p_pkg::CH_MINUS: code = i2p_pkg::OP_SUB;
      i2p_pkg::CH_STAR:  code = i2p_pkg::OP_MUL;
      i2p_pkg::CH_SLASH: code = i2p_pkg::OP_DIV;
      default:           code = i2p_pkg::OP_NONE;
    endcase
    if (sym == i2p_pkg::CH_SPACE || sym == i2p_pkg::CH_NUL) begin
      // skip
    end else if (code != i2p_pkg::OP_NONE) begin
      while (stk_cnt > 0 && rank_of(code) <= rank_of(opstk[stk_cnt - 1])) pop_to_result();
      push_code(code);
    end else if (sym == i2p_pkg::CH_LPAR) begin
      push_code(i2p_pkg::OP_LPAR);
    end else if (sym == i2p_pkg::CH_LBRK) begin
      push_code(i2p_pkg::OP_LBRK);
    end else if (sym == i2p_pkg::CH_RPAR || sym == i2p_pkg::CH_RBRK) begin
      while (stk_cnt > 0 && opstk[stk_cnt - 1] != i2p_pkg::OP_LPAR &&
             opstk[stk_cnt - 1] != i2p_pkg::OP_LBRK)
        pop_to_result();
      if (stk_cnt > 0) stk_cnt--;
      else err_flags[i2p_pkg::ERR_UNMATCHED_BIT] = 1'b1;
    end else begin
      add_result(sym, 1'b0, ERR_OK);
    end
    // Flush and terminate the expression
    if (fin) begin
      while (stk_cnt > 0) pop_to_result();
      add_result(i2p_pkg::CH_NUL, 1'b1, err_flags);
      stk_cnt = 0;
      err_flags = 2'b00;
    end
    if (step_res.size() > 0) begin
      tail = step_res.pop_back();
      tail.run_last = 1'b1;
      step_res.push_back(tail);
    end
  endtask

  task automatic add_item(input logic [7:0] sym, input logic fin);
    stim_row_t r;
    r = '0;
    r.sym = sym;
    r.fin = fin;
    stim_q.push_back(r);
  endtask

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    i2p_pkg::out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      shunt_symbol(in_item.symbol, in_item.final_byte);
      if (cur_row.known) postfix_q.push_back(cur_row.res);
      else foreach (step_res[k]) postfix_q.push_back(step_res[k]);
    end
    if (rst_n && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        note_failure($sformatf("unexpected result sym=%h last=%b end=%b err=%0d",
                     out_item.out_symbol, out_item.run_last, out_item.expression_end,
                     out_item.error_code));
      end else begin
        want = postfix_q.pop_front();
        if (out_item.out_symbol !== want.out_symbol || out_item.run_last !== want.run_last ||
            out_item.expression_end !== want.expression_end ||
            out_item.error_code !== want.error_code) begin
          note_failure($sformatf(
            "expected sym=%h last=%b end=%b err=%0d, got sym=%h last=%b end=%b err=%0d",
            want.out_symbol, want.run_last, want.expression_end, want.error_code,
            out_item.out_symbol, out_item.run_last, out_item.expression_end,
            out_item.error_code));
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off to back up the block
  initial begin
    int stall;
    int got;
    bit steady;
    got = 0;
    steady = 1'b0;
    wait (rst_n);
    forever begin
      if (got % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 9);
      if (got == 60) stall = 250;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

  // Hard limit on run time
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int t;
    int terms;
    int depth;
    int kind;
    int gap;
    int sent;
    int drain;
    bit steady;
    stim_row_t row;
    stim_row_t last;
    logic [7:0] sym;

    // Walk the directed table first
    foreach (directed_tbl[k]) stim_q.push_back(directed_tbl[k]);

    // Random expressions: mostly well formed, some deep, broken or pure noise
    while (stim_q.size() < 450) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 10))
          add_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else begin
        depth = 0;
        if (kind == 1) begin
          repeat ($urandom_range(12, 20)) begin
            add_item($urandom_range(0, 1) ? i2p_pkg::CH_LPAR : i2p_pkg::CH_LBRK, 1'b0);
            depth++;
          end
        end
        terms = $urandom_range(1, 7);
        for (t = 0; t < terms; t++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_item($urandom_range(0, 1) ? i2p_pkg::CH_LPAR : i2p_pkg::CH_LBRK, 1'b0);
            depth++;
          end
          if ($urandom_range(0, 4) == 0) add_item(i2p_pkg::CH_SPACE, 1'b0);
          case ($urandom_range(0, 3))
            0:       sym = 8'("a" + $urandom_range(0, 25));
            1:       sym = 8'("0" + $urandom_range(0, 9));
            default: sym = 8'($urandom_range(0, 255));
          endcase
          add_item(sym, 1'b0);
          while (depth > 0 && $urandom_range(0, 2) == 0) begin
            add_item($urandom_range(0, 1) ? i2p_pkg::CH_RPAR : i2p_pkg::CH_RBRK, 1'b0);
            depth--;
          end
          if (t < terms - 1) add_item(OPER_CH[$urandom_range(0, 3)], 1'b0);
        end
        // Unmatched closers, or openers left for the flush
        if (kind == 2) depth += $urandom_range(1, 2);
        if (kind != 3) begin
          while (depth > 0) begin
            add_item($urandom_range(0, 1) ? i2p_pkg::CH_RPAR : i2p_pkg::CH_RBRK, 1'b0);
            depth--;
          end
        end
      end
      // Close the expression on its last byte or on a trailing space
      if ($urandom_range(0, 3) == 0) begin
        add_item(i2p_pkg::CH_SPACE, 1'b1);
      end else begin
        last = stim_q.pop_back();
        last.fin = 1'b1;
        stim_q.push_back(last);
      end
    end

    // Hold reset, then release
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Offer each item, idling at random before it except in steady stretches
    sent = 0;
    steady = 1'b0;
    foreach (stim_q[k]) begin
      row = stim_q[k];
      if (sent % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = steady ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_item <= '{symbol: row.sym, final_byte: row.fin};
      cur_row <= row;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    drain = 0;
    while (postfix_q.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (postfix_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", postfix_q.size()));

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: infix_to_postfix_converter_top.f
rtl/i2p_pkg.sv
rtl/i2p_front.sv
rtl/i2p_queue.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter_top.sv
rtl/i2p_checker.sv
sim/testbench.sv
